// ===== rtl/sfesc_pkg.sv =====
// shared types, constants and the exp series helper for the shelf filter / soft clip block
// no dependencies; used by sfesc_ctrl, sfesc_datapath and the top level
`default_nettype none

package sfesc_pkg;

   localparam int DEF_SAMPLE_WIDTH    = 24;
   localparam int DEF_EXP_TABLE_DEPTH = 256;

   // register file layout
   localparam int COEF_W      = 24;
   localparam int GAIN_W      = 15;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int COEF_FRAC   = 22;

   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_B0  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_B1  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_A1  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEG_GAIN = 2'd3;

   // unity in Q2.22, zero, and 0.71 in Q0.15
   localparam logic [COEF_W-1:0] COEF_B0_RESET  = 24'd4194304;
   localparam logic [COEF_W-1:0] COEF_ZERO      = 24'd0;
   localparam logic [GAIN_W-1:0] NEG_GAIN_RESET = 15'd23265;

   // exp table entries are unsigned Q0.24, up to and including 1.0
   localparam int                EXP_W   = 25;
   localparam logic [EXP_W-1:0]  EXP_ONE = 25'd16777216;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_MUL_B0,
      OP_MUL_B1,
      OP_MUL_A1,
      OP_ACC_SUB,
      OP_SAT,
      OP_SCALE,
      OP_RD_LO,
      OP_RD_HI,
      OP_MUL_D,
      OP_EXP,
      OP_MUL_G,
      OP_EMIT,
      OP_CLIP
   } dp_op_type;

   typedef struct packed {
      logic      load;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic y_neg;
      logic out_free;
   } dp_status_type;

   // exp(-f) in Q0.32 for f in Q0.32 below one, 25-term series, elaboration use only
   function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      term = 64'd1 << 32;
      pos  = 64'd1 << 32;
      neg  = 64'd0;
      for (int k = 1; k <= 24; k++) begin
         term = ((term * f) >> 32) / 64'(k);
         if (k[0]) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      return pos - neg;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/shelf_filter_exp_soft_clip.sv =====
// First-order IIR shelf filter (y = b0*x + b1*x_prev - a1*y_prev, Q4.20 samples,
// Q2.22 coefficients, rounded and saturated) followed by an exponential soft clip:
// non-negative results pass, a negative result v leaves as gain*(exp(v)-1), with exp
// read from a table over [-8,0] and linearly interpolated. One multiplier is shared
// by all products and the table is read one entry per cycle. Every item runs three
// filter products and saturation; an item with a negative output then also runs
// scale, two table reads, interpolation and gain products. The next item is not
// taken until the last one writes its result to the output register, and may be
// taken while that result still waits there. Configuration writes take effect at
// once; write only while no item is in flight.
// depends on sfesc_pkg, sfesc_ctrl and sfesc_datapath
`default_nettype none

module shelf_filter_exp_soft_clip #(
   parameter int SAMPLE_WIDTH    = sfesc_pkg::DEF_SAMPLE_WIDTH,
   parameter int EXP_TABLE_DEPTH = sfesc_pkg::DEF_EXP_TABLE_DEPTH,
   localparam int TDATA_W        = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input items
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [TDATA_W-1:0]                req_tdata,   // sample_in, zero padded
   // result items
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [TDATA_W-1:0]                     rsp_tdata,   // sample_out, zero padded
   // register writes
   input  wire logic                              csr_we,
   input  wire logic [sfesc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sfesc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   sfesc_pkg::dp_cmd_type    cmd;
   sfesc_pkg::dp_status_type status;
   logic [SAMPLE_WIDTH-1:0]  rsp_data;

   sfesc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   sfesc_datapath #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  ($signed(req_tdata[SAMPLE_WIDTH-1:0])),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tdata = TDATA_W'(rsp_data);

endmodule

`default_nettype wire

// ===== rtl/sfesc_ctrl.sv =====
// sequencer for the shelf filter / soft clip block: issues one datapath op per cycle
// depends on sfesc_pkg for the op codes and the command / status structs
`default_nettype none

module sfesc_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire sfesc_pkg::dp_status_type status,
   output sfesc_pkg::dp_cmd_type        cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_F1,
      ST_F2,
      ST_F3,
      ST_F4,
      ST_SAT,
      ST_CHECK,
      ST_N1,
      ST_N2,
      ST_N3,
      ST_N4,
      ST_N5,
      ST_N6,
      ST_EMIT
   } state_type;

   state_type            state_ff;
   sfesc_pkg::dp_op_type op_ff;
   logic                 ready_ff;
   logic                 accept;

   assign accept    = req_valid && ready_ff;
   assign req_ready = ready_ff;
   assign cmd.load  = accept;
   assign cmd.op    = op_ff;

   // op_ff is the op the datapath runs in the current cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= sfesc_pkg::OP_NOP;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff    <= sfesc_pkg::OP_MUL_B0;
                  ready_ff <= 1'b0;
                  state_ff <= ST_F1;
               end else begin
                  op_ff <= sfesc_pkg::OP_NOP;
               end
            end
            ST_F1: begin
               op_ff    <= sfesc_pkg::OP_MUL_B1;
               state_ff <= ST_F2;
            end
            ST_F2: begin
               op_ff    <= sfesc_pkg::OP_MUL_A1;
               state_ff <= ST_F3;
            end
            ST_F3: begin
               op_ff    <= sfesc_pkg::OP_ACC_SUB;
               state_ff <= ST_F4;
            end
            ST_F4: begin
               op_ff    <= sfesc_pkg::OP_SAT;
               state_ff <= ST_SAT;
            end
            ST_SAT: begin
               op_ff    <= sfesc_pkg::OP_NOP;
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (status.y_neg) begin
                  op_ff    <= sfesc_pkg::OP_SCALE;
                  state_ff <= ST_N1;
               end else if (status.out_free) begin
                  op_ff    <= sfesc_pkg::OP_EMIT;
                  ready_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  op_ff <= sfesc_pkg::OP_NOP;
               end
            end
            ST_N1: begin
               op_ff    <= sfesc_pkg::OP_RD_LO;
               state_ff <= ST_N2;
            end
            ST_N2: begin
               op_ff    <= sfesc_pkg::OP_RD_HI;
               state_ff <= ST_N3;
            end
            ST_N3: begin
               op_ff    <= sfesc_pkg::OP_MUL_D;
               state_ff <= ST_N4;
            end
            ST_N4: begin
               op_ff    <= sfesc_pkg::OP_EXP;
               state_ff <= ST_N5;
            end
            ST_N5: begin
               op_ff    <= sfesc_pkg::OP_MUL_G;
               state_ff <= ST_N6;
            end
            ST_N6: begin
               op_ff    <= sfesc_pkg::OP_NOP;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (status.out_free) begin
                  op_ff    <= sfesc_pkg::OP_CLIP;
                  ready_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  op_ff <= sfesc_pkg::OP_NOP;
               end
            end
            default: begin
               op_ff    <= sfesc_pkg::OP_NOP;
               ready_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sfesc_datapath.sv =====
// datapath: registers, shared multiplier, accumulator, exp table and output register
// depends on sfesc_pkg; driven by sfesc_ctrl through dp_cmd_type
`default_nettype none

module sfesc_datapath #(
   parameter int SAMPLE_WIDTH    = sfesc_pkg::DEF_SAMPLE_WIDTH,
   parameter int EXP_TABLE_DEPTH = sfesc_pkg::DEF_EXP_TABLE_DEPTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire sfesc_pkg::dp_cmd_type                 cmd,
   output sfesc_pkg::dp_status_type                   status,
   input  wire logic signed [SAMPLE_WIDTH-1:0]        req_data,
   input  wire logic                                  csr_we,
   input  wire logic [sfesc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [sfesc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [SAMPLE_WIDTH-1:0]                    rsp_data
);

   localparam int SW     = SAMPLE_WIDTH;
   localparam int FRAC   = SW - 4;
   localparam int EW     = sfesc_pkg::EXP_W;
   localparam int CW     = sfesc_pkg::COEF_W;
   localparam int GW     = sfesc_pkg::GAIN_W;
   localparam int CF     = sfesc_pkg::COEF_FRAC;
   localparam int AW     = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int MA_W   = EW + 1;
   localparam int MB_W   = ((SW > EW) ? SW : EW) + 1;
   localparam int P_W    = MA_W + MB_W;
   localparam int ACC_W  = SW + 26;
   localparam int MAG_W  = 40;
   localparam int RND_SH = 39 - FRAC;

   localparam logic signed [ACC_W-1:0] ACC_HALF =
      {{(ACC_W-CF){1'b0}}, 1'b1, {(CF-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] ACC_SMAX = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_SMIN = {{(ACC_W-SW+1){1'b1}}, {(SW-1){1'b0}}};
   localparam logic [MAG_W-1:0]        MAG_HALF = MAG_W'(1) << (RND_SH - 1);

   typedef logic [EW-1:0] rom_type [0:EXP_TABLE_DEPTH];

   // exp(-8 + 8*i/depth) in Q0.24, built at elaboration from the series
   function automatic rom_type build_exp_rom();
      rom_type     r;
      logic [63:0] eh;
      logic [63:0] e1;
      logic [63:0] t;
      logic [63:0] val;
      int          m;
      eh = sfesc_pkg::exp_neg_frac(64'h0000_0000_8000_0000);
      e1 = (eh * eh) >> 32;
      for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
         t   = (64'(EXP_TABLE_DEPTH - i) << 35) / EXP_TABLE_DEPTH;
         m   = int'(t >> 32);
         val = sfesc_pkg::exp_neg_frac({32'd0, t[31:0]});
         for (int j = 0; j < 8; j++) begin
            if (j < m) begin
               val = (val * e1) >> 32;
            end
         end
         r[i] = EW'((val + 64'd128) >> 8);
      end
      return r;
   endfunction

   localparam rom_type EXP_ROM = build_exp_rom();

   logic signed [CW-1:0]    coef_b0_ff, coef_b0_in;
   logic signed [CW-1:0]    coef_b1_ff, coef_b1_in;
   logic signed [CW-1:0]    coef_a1_ff, coef_a1_in;
   logic [GW-1:0]           gain_ff, gain_in;
   logic signed [SW-1:0]    x_ff, x_in;
   logic signed [SW-1:0]    prev_input_ff, prev_input_in;
   logic signed [SW-1:0]    prev_filtered_ff, prev_filtered_in;
   logic signed [P_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [SW-1:0]    y_ff, y_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic [SW-2:0]           rem_ff, rem_in;
   logic [EW-1:0]           rom_q_ff, rom_q_in;
   logic [EW-1:0]           lo_ff, lo_in;
   logic [EW-1:0]           em1_ff, em1_in;
   logic [SW-1:0]           out_data_ff, out_data_in;
   logic                    out_valid_ff, out_valid_in;

   logic signed [MA_W-1:0]  mul_a;
   logic signed [MB_W-1:0]  mul_b;
   logic signed [P_W-1:0]   mul_p;
   logic [EW-1:0]           step_d;
   logic [AW-1:0]           rom_addr;
   logic signed [ACC_W-1:0] acc_prod;
   logic signed [ACC_W-1:0] acc_rnd;
   logic signed [ACC_W-1:0] y_full;
   logic signed [SW-1:0]    y_sat;
   logic [EW:0]             e_sum;
   logic [MAG_W-1:0]        mag;

   assign status.y_neg    = y_ff[SW-1];
   assign status.out_free = !out_valid_ff || rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign rsp_data        = out_data_ff;

   // interpolation step, hi is in rom_q_ff and lo in lo_ff during the step multiply
   assign step_d = (rom_q_ff >= lo_ff) ? (rom_q_ff - lo_ff) : '0;

   // shared multiplier operand select
   always_comb begin
      case (cmd.op)
         sfesc_pkg::OP_MUL_B0: begin
            mul_a = MA_W'(coef_b0_ff);
            mul_b = MB_W'(x_ff);
         end
         sfesc_pkg::OP_MUL_B1: begin
            mul_a = MA_W'(coef_b1_ff);
            mul_b = MB_W'(prev_input_ff);
         end
         sfesc_pkg::OP_MUL_A1: begin
            mul_a = MA_W'(coef_a1_ff);
            mul_b = MB_W'(prev_filtered_ff);
         end
         sfesc_pkg::OP_SCALE: begin
            // y + 8 for negative y is y with its sign bit dropped
            mul_a = MA_W'(EXP_TABLE_DEPTH);
            mul_b = $signed({{(MB_W-SW+1){1'b0}}, y_ff[SW-2:0]});
         end
         sfesc_pkg::OP_MUL_D: begin
            mul_a = $signed({1'b0, step_d});
            mul_b = $signed({{(MB_W-SW+1){1'b0}}, rem_ff});
         end
         sfesc_pkg::OP_MUL_G: begin
            mul_a = $signed({{(MA_W-GW){1'b0}}, gain_ff});
            mul_b = $signed({{(MB_W-EW){1'b0}}, em1_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign rom_addr = (cmd.op == sfesc_pkg::OP_RD_LO) ? prod_ff[SW-1 +: AW]
                                                      : idx_ff + AW'(1);

   assign acc_prod = ACC_W'(prod_ff);
   assign acc_rnd  = acc_ff + ACC_HALF;
   assign y_full   = acc_rnd >>> CF;

   always_comb begin
      if (y_full > ACC_SMAX) begin
         y_sat = ACC_SMAX[SW-1:0];
      end else if (y_full < ACC_SMIN) begin
         y_sat = ACC_SMIN[SW-1:0];
      end else begin
         y_sat = y_full[SW-1:0];
      end
   end

   assign e_sum = {1'b0, lo_ff} + {1'b0, prod_ff[SW-1 +: EW]};
   assign mag   = (prod_ff[MAG_W-1:0] + MAG_HALF) >> RND_SH;

   always_comb begin
      coef_b0_in       = coef_b0_ff;
      coef_b1_in       = coef_b1_ff;
      coef_a1_in       = coef_a1_ff;
      gain_in          = gain_ff;
      x_in             = x_ff;
      prev_input_in    = prev_input_ff;
      prev_filtered_in = prev_filtered_ff;
      prod_in          = prod_ff;
      acc_in           = acc_ff;
      y_in             = y_ff;
      idx_in           = idx_ff;
      rem_in           = rem_ff;
      rom_q_in         = rom_q_ff;
      lo_in            = lo_ff;
      em1_in           = em1_ff;
      out_data_in      = out_data_ff;
      out_valid_in     = out_valid_ff && !rsp_ready;

      if (csr_we) begin
         case (csr_index)
            sfesc_pkg::CSR_COEF_B0:  coef_b0_in = csr_wdata[CW-1:0];
            sfesc_pkg::CSR_COEF_B1:  coef_b1_in = csr_wdata[CW-1:0];
            sfesc_pkg::CSR_COEF_A1:  coef_a1_in = csr_wdata[CW-1:0];
            sfesc_pkg::CSR_NEG_GAIN: gain_in    = csr_wdata[GW-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         x_in = req_data;
      end

      case (cmd.op)
         sfesc_pkg::OP_MUL_B0: begin
            prod_in = mul_p;
         end
         sfesc_pkg::OP_MUL_B1: begin
            prod_in = mul_p;
            acc_in  = acc_prod;
         end
         sfesc_pkg::OP_MUL_A1: begin
            prod_in = mul_p;
            acc_in  = acc_ff + acc_prod;
         end
         sfesc_pkg::OP_ACC_SUB: begin
            acc_in = acc_ff - acc_prod;
         end
         sfesc_pkg::OP_SAT: begin
            y_in             = y_sat;
            prev_input_in    = x_ff;
            prev_filtered_in = y_sat;
         end
         sfesc_pkg::OP_SCALE: begin
            prod_in = mul_p;
         end
         sfesc_pkg::OP_RD_LO: begin
            idx_in   = prod_ff[SW-1 +: AW];
            rem_in   = prod_ff[SW-2:0];
            rom_q_in = EXP_ROM[rom_addr];
         end
         sfesc_pkg::OP_RD_HI: begin
            lo_in    = rom_q_ff;
            rom_q_in = EXP_ROM[rom_addr];
         end
         sfesc_pkg::OP_MUL_D: begin
            prod_in = mul_p;
         end
         sfesc_pkg::OP_EXP: begin
            if (e_sum > {1'b0, sfesc_pkg::EXP_ONE}) begin
               em1_in = '0;
            end else begin
               em1_in = sfesc_pkg::EXP_ONE - e_sum[EW-1:0];
            end
         end
         sfesc_pkg::OP_MUL_G: begin
            prod_in = mul_p;
         end
         sfesc_pkg::OP_EMIT: begin
            out_data_in  = y_ff;
            out_valid_in = 1'b1;
         end
         sfesc_pkg::OP_CLIP: begin
            // magnitude rounded half up, then negated
            out_data_in  = -mag[SW-1:0];
            out_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff       <= sfesc_pkg::COEF_B0_RESET;
         coef_b1_ff       <= sfesc_pkg::COEF_ZERO;
         coef_a1_ff       <= sfesc_pkg::COEF_ZERO;
         gain_ff          <= sfesc_pkg::NEG_GAIN_RESET;
         prev_input_ff    <= '0;
         prev_filtered_ff <= '0;
         out_valid_ff     <= 1'b0;
      end else begin
         coef_b0_ff       <= coef_b0_in;
         coef_b1_ff       <= coef_b1_in;
         coef_a1_ff       <= coef_a1_in;
         gain_ff          <= gain_in;
         prev_input_ff    <= prev_input_in;
         prev_filtered_ff <= prev_filtered_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      y_ff        <= y_in;
      idx_ff      <= idx_in;
      rem_ff      <= rem_in;
      rom_q_ff    <= rom_q_in;
      lo_ff       <= lo_in;
      em1_ff      <= em1_in;
      out_data_ff <= out_data_in;
   end

endmodule

`default_nettype wire
